/* src/cbam_pkg.sv */
// ----------------------------------------------------------------------------
// cbam_pkg
// Shared types and constants for the capture buffer admission monitor.
// ----------------------------------------------------------------------------
package cbam_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QTimeW  = TimeW + FracW;
  localparam int unsigned PeriodW = 40;
  localparam int unsigned LimitW  = 32;
  localparam int unsigned FramesW = 16;
  localparam int unsigned ProdW   = FramesW + PeriodW;
  localparam int unsigned TotalW  = 40;
  localparam int unsigned KeptW   = 14;
  localparam int unsigned SlotW   = 7;
  localparam int unsigned DepthW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 40;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 136;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_LIMIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LIMIT  = 2'd2;

  localparam logic [PeriodW-1:0] FramePeriodReset = 40'd1365333333;
  localparam logic [LimitW-1:0]  GapLimitReset    = 32'd100000;

  localparam logic REQ_BUFFER  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_ABORT    = 2'd1,
    VERDICT_COMPLETE = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_INPUT_LOSS = 3'd1,
    ERR_CLOCK_GAP  = 3'd2,
    ERR_QUEUE_FULL = 3'd3,
    ERR_BAD_BUFFER = 3'd4
  } error_e;

  typedef struct packed {
    logic [TimeW-1:0] gap_ns;
    logic             over_limit;
  } gap_res_t;

endpackage

/* src/cbam_gap_unit.sv */
// ----------------------------------------------------------------------------
// cbam_gap_unit
// Timestamp deviation against the predicted arrival time and limit check.
// ----------------------------------------------------------------------------
module cbam_gap_unit
  import cbam_pkg::*;
(
  input  logic [TimeW-1:0]  adc_time_i,
  input  logic [TimeW-1:0]  pred_base_i,
  input  logic [ProdW-1:0]  pred_prod_i,
  input  logic [LimitW-1:0] gap_limit_i,
  output gap_res_t          gap_o
);

  logic [QTimeW-1:0] diff;
  logic [QTimeW-1:0] gap_q;
  logic [QTimeW-1:0] limit_q;

  // modular distance in q16 ns, prediction kept as base plus product
  assign diff    = {adc_time_i, {FracW{1'b0}}} - {pred_base_i, {FracW{1'b0}}}
                   - {{(QTimeW-ProdW){1'b0}}, pred_prod_i};
  assign gap_q   = diff[QTimeW-1] ? (~diff + {{(QTimeW-1){1'b0}}, 1'b1}) : diff;
  assign limit_q = {{(QTimeW-LimitW-FracW){1'b0}}, gap_limit_i, {FracW{1'b0}}};

  assign gap_o.gap_ns     = gap_q[QTimeW-1:FracW];
  assign gap_o.over_limit = gap_q > limit_q;

endmodule

/* src/capture_buffer_admission_monitor.sv */
// ----------------------------------------------------------------------------
// capture_buffer_admission_monitor
// Admits capture buffers into a bounded slot queue, polices timestamps,
// latches the first error and tracks occupancy, peak and largest gap.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: buffer word, tuser: req_type
// m_axis    out  tvalid/tready          tdata: result word
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// one word per cycle unless the result stalls; an accepted word passes
// the input register, then the result register after the single decision pass
// rate set by the 64 bit gap path and the 16x40 prediction multiply
// reset clears config to defaults, error, counters, queue and both stages
// a stalled result holds in the output register; the input register still
// takes a word, and s_axis_tready_o drops only when both stages are full
// ----------------------------------------------------------------------------
module capture_buffer_admission_monitor
  import cbam_pkg::*;
#(
  parameter int unsigned QUEUE_SLOTS       = 128,
  parameter int unsigned MAX_BUFFER_FRAMES = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // frame_count, adc_time_ns, time_valid, data_present, overflow_flag,
  // underflow_flag, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // verdict, error_code, kept_frames, slot_index, queue_depth,
  // queue_high_water, max_gap_ns, accepted_total, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned OccW    = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned SlotIdW = $clog2(QUEUE_SLOTS);

  // configuration
  logic [PeriodW-1:0] period_q;
  logic [LimitW-1:0]  gap_limit_q;
  logic [TotalW-1:0]  frame_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= FramePeriodReset;
      gap_limit_q   <= GapLimitReset;
      frame_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_PERIOD: period_q      <= cfg_data_i[PeriodW-1:0];
        CFG_GAP_LIMIT:    gap_limit_q   <= cfg_data_i[LimitW-1:0];
        CFG_FRAME_LIMIT:  frame_limit_q <= cfg_data_i[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_v_q;
  logic               in_req_q;
  logic [FramesW-1:0] in_frames_q;
  logic [TimeW-1:0]   in_adc_q;
  logic               in_tvalid_q;
  logic               in_data_q;
  logic               in_ovf_q;
  logic               in_unf_q;
  logic               out_v_q;
  logic               adv;

  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q    <= s_axis_tuser_i;
      in_frames_q <= s_axis_tdata_i[15:0];
      in_adc_q    <= s_axis_tdata_i[63:16];
      in_tvalid_q <= s_axis_tdata_i[64];
      in_data_q   <= s_axis_tdata_i[65];
      in_ovf_q    <= s_axis_tdata_i[66];
      in_unf_q    <= s_axis_tdata_i[67];
    end
  end

  // monitor state
  error_e             err_q, err_d;
  logic               started_q, started_d;
  logic [TimeW-1:0]   pred_base_q, pred_base_d;
  logic [ProdW-1:0]   pred_prod_q, pred_prod_d;
  logic [TimeW-1:0]   max_gap_q, max_gap_d;
  logic [TotalW-1:0]  admitted_q, admitted_d;
  logic [SlotIdW-1:0] slot_q, slot_d;
  logic [OccW-1:0]    occ_q, occ_d;
  logic [OccW-1:0]    peak_q, peak_d;

  gap_res_t           gap;
  logic [ProdW-1:0]   prod;
  logic [TotalW-1:0]  room;
  logic               bad_buf;
  logic               limited;
  verdict_e           verdict;
  logic [FramesW-1:0] kept;
  logic [SlotIdW-1:0] slot_sel;
  logic [31:0]        slot_ext;
  logic [31:0]        occ_ext;
  logic [31:0]        peak_ext;

  cbam_gap_unit u_gap (
    .adc_time_i  (in_adc_q),
    .pred_base_i (pred_base_q),
    .pred_prod_i (pred_prod_q),
    .gap_limit_i (gap_limit_q),
    .gap_o       (gap)
  );

  assign prod    = ProdW'(in_frames_q) * ProdW'(period_q);
  assign limited = frame_limit_q != '0;
  assign room    = (frame_limit_q > admitted_q) ? (frame_limit_q - admitted_q) : '0;
  assign bad_buf = !in_data_q || (in_frames_q == '0) ||
                   (in_frames_q > FramesW'(MAX_BUFFER_FRAMES)) || !in_tvalid_q;

  always_comb begin
    err_d       = err_q;
    started_d   = started_q;
    pred_base_d = pred_base_q;
    pred_prod_d = pred_prod_q;
    max_gap_d   = max_gap_q;
    admitted_d  = admitted_q;
    slot_d      = slot_q;
    occ_d       = occ_q;
    peak_d      = peak_q;
    verdict     = VERDICT_CONTINUE;
    kept        = '0;
    slot_sel    = '0;
    if (in_req_q == REQ_RELEASE) begin
      if (occ_q != '0) begin
        occ_d = occ_q - OccW'(1);
      end
    end else if (err_q != ERR_NONE) begin
      verdict = VERDICT_ABORT;
    end else if (in_ovf_q || in_unf_q) begin
      err_d   = ERR_INPUT_LOSS;
      verdict = VERDICT_ABORT;
    end else if (bad_buf) begin
      err_d   = ERR_BAD_BUFFER;
      verdict = VERDICT_ABORT;
    end else begin
      if (started_q && (gap.gap_ns > max_gap_q)) begin
        max_gap_d = gap.gap_ns;
      end
      if (started_q && gap.over_limit) begin
        err_d   = ERR_CLOCK_GAP;
        verdict = VERDICT_ABORT;
      end else begin
        pred_base_d = in_adc_q;
        pred_prod_d = prod;
        if (occ_q >= OccW'(QUEUE_SLOTS)) begin
          err_d   = ERR_QUEUE_FULL;
          verdict = VERDICT_ABORT;
        end else begin
          kept = (limited && (TotalW'(in_frames_q) > room)) ? room[FramesW-1:0]
                                                             : in_frames_q;
          slot_sel   = slot_q;
          slot_d     = (slot_q == SlotIdW'(QUEUE_SLOTS - 1)) ? '0
                                                              : slot_q + SlotIdW'(1);
          occ_d      = occ_q + OccW'(1);
          if (occ_d > peak_q) begin
            peak_d = occ_d;
          end
          admitted_d = admitted_q + TotalW'(kept);
          started_d  = 1'b1;
          if (limited && (TotalW'(in_frames_q) >= room)) begin
            verdict = VERDICT_COMPLETE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= ERR_NONE;
      started_q   <= 1'b0;
      pred_base_q <= '0;
      pred_prod_q <= '0;
      max_gap_q   <= '0;
      admitted_q  <= '0;
      slot_q      <= '0;
      occ_q       <= '0;
      peak_q      <= '0;
    end else if (adv) begin
      err_q       <= err_d;
      started_q   <= started_d;
      pred_base_q <= pred_base_d;
      pred_prod_q <= pred_prod_d;
      max_gap_q   <= max_gap_d;
      admitted_q  <= admitted_d;
      slot_q      <= slot_d;
      occ_q       <= occ_d;
      peak_q      <= peak_d;
    end
  end

  // result register
  logic [OutDataW-1:0] out_data_q;

  assign slot_ext = 32'(slot_sel);
  assign occ_ext  = 32'(occ_d);
  assign peak_ext = 32'(peak_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {6'b0, admitted_d, max_gap_d, peak_ext[DepthW-1:0],
                     occ_ext[DepthW-1:0], slot_ext[SlotW-1:0], kept[KeptW-1:0],
                     err_d, verdict};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* src/cbam_checker.sv */
// ----------------------------------------------------------------------------
// cbam_checker
// Port level checks on the result stream of the admission monitor.
// ----------------------------------------------------------------------------
module cbam_checker
  import cbam_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0]        verdict;
  logic [2:0]        err;
  logic [DepthW-1:0] depth;
  logic [DepthW-1:0] peak_depth;

  assign verdict    = m_axis_tdata_o[1:0];
  assign err        = m_axis_tdata_o[4:2];
  assign depth      = m_axis_tdata_o[33:26];
  assign peak_depth = m_axis_tdata_o[41:34];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_abort_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (verdict == VERDICT_ABORT) |-> err != ERR_NONE)
    else $error("abort without a latched error");

  a_complete_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (verdict == VERDICT_COMPLETE) |-> err == ERR_NONE)
    else $error("completion reported after an error");

  a_peak_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> depth <= peak_depth)
    else $error("queue depth above peak occupancy");

endmodule

bind capture_buffer_admission_monitor cbam_checker u_cbam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
